// ----- rtl/ogpr_pkg.sv -----
// ----------------------------------------------------------------------------
// ogpr_pkg
// Shared constants, codes and types of the occupancy grid polygon raster unit.
// ----------------------------------------------------------------------------
package ogpr_pkg;

  localparam int GRID_COLUMNS = 64;
  localparam int GRID_ROWS    = 64;
  localparam int MAX_VERTICES = 16;
  localparam int MIN_VERTICES = 3;

  localparam int PIX_W     = 10;
  localparam int CFG_W     = 11;
  localparam int CNT_CFG_W = 7;
  localparam int TYPE_W    = 3;
  localparam int STAT_W    = 2;

  localparam int COL_W      = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int ROW_W      = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int GRID_AW    = ROW_W + COL_W;
  localparam int GRID_DEPTH = GRID_ROWS * (2 ** COL_W);
  localparam int CNT_W      =
    $clog2(((GRID_COLUMNS > GRID_ROWS) ? GRID_COLUMNS : GRID_ROWS) + 1);
  localparam int VI_W       = $clog2(MAX_VERTICES);
  localparam int VC_W       = $clog2(MAX_VERTICES + 2);
  localparam int BND_W      = PIX_W + 2;

  localparam int DIV_NW = 2 * PIX_W;
  localparam int DIV_DW = CFG_W;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [1:0] OP_VERTEX = 2'd0;
  localparam logic [1:0] OP_CHECK  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [TYPE_W-1:0] TYPE_OBSTACLE   = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_HIGHEST    = 3'd4;
  localparam logic [TYPE_W-1:0] TYPE_OUT_OF_MAP = 3'd5;

  localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FEW  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_MANY = 2'd2;

  localparam logic [2:0] REG_CELL_WIDTH   = 3'd0;
  localparam logic [2:0] REG_CELL_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_MAP_WIDTH    = 3'd2;
  localparam logic [2:0] REG_MAP_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_CELLS_ACROSS = 3'd4;
  localparam logic [2:0] REG_CELLS_DOWN   = 3'd5;

  typedef struct packed {
    logic [CFG_W-1:0] cell_w;
    logic [CFG_W-1:0] cell_h;
    logic [CFG_W-1:0] map_w;
    logic [CFG_W-1:0] map_h;
    logic [CNT_W-1:0] cols;
    logic [CNT_W-1:0] rows;
  } cfg_t;

endpackage

// ----- rtl/ogpr_ram.sv -----
// ----------------------------------------------------------------------------
// ogpr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ogpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ogpr_div.sv -----
// ----------------------------------------------------------------------------
// ogpr_div
// Shared restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module ogpr_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [ogpr_pkg::DIV_NW-1:0] num,
  input  logic [ogpr_pkg::DIV_DW-1:0] den,
  output logic [ogpr_pkg::DIV_NW-1:0] quo,
  output logic [ogpr_pkg::DIV_DW-1:0] rem,
  output logic                      done
);
  import ogpr_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DIV_DW-1:0] dreg;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   trial;
  logic              take;

  assign shifted = {rem, quo[DIV_NW-1]};
  assign trial   = shifted - {1'b0, dreg};
  assign take    = shifted >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        quo  <= num;
        rem  <= '0;
        dreg <= den;
        cnt  <= CW'(DIV_NW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= take ? trial[DIV_DW-1:0] : shifted[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/ogpr_cfg.sv -----
// ----------------------------------------------------------------------------
// ogpr_cfg
// APB register file for cell size, map size and grid extent.
// ----------------------------------------------------------------------------
module ogpr_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ogpr_pkg::APB_AW-1:0] paddr,
  input  logic [ogpr_pkg::APB_DW-1:0] pwdata,
  output logic [ogpr_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output ogpr_pkg::cfg_t              cfg
);
  import ogpr_pkg::*;

  logic [CFG_W-1:0]     cell_width, cell_height, map_width, map_height;
  logic [CNT_CFG_W-1:0] cells_across, cells_down;
  logic [2:0]           idx;

  assign idx    = paddr[APB_AW-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width   <= CFG_W'(16);
      cell_height  <= CFG_W'(16);
      map_width    <= CFG_W'(1024);
      map_height   <= CFG_W'(1024);
      cells_across <= CNT_CFG_W'(64);
      cells_down   <= CNT_CFG_W'(64);
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_CELL_WIDTH:   cell_width   <= pwdata[CFG_W-1:0];
        REG_CELL_HEIGHT:  cell_height  <= pwdata[CFG_W-1:0];
        REG_MAP_WIDTH:    map_width    <= pwdata[CFG_W-1:0];
        REG_MAP_HEIGHT:   map_height   <= pwdata[CFG_W-1:0];
        REG_CELLS_ACROSS: cells_across <= pwdata[CNT_CFG_W-1:0];
        REG_CELLS_DOWN:   cells_down   <= pwdata[CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CELL_WIDTH:   prdata = APB_DW'(cell_width);
      REG_CELL_HEIGHT:  prdata = APB_DW'(cell_height);
      REG_MAP_WIDTH:    prdata = APB_DW'(map_width);
      REG_MAP_HEIGHT:   prdata = APB_DW'(map_height);
      REG_CELLS_ACROSS: prdata = APB_DW'(cells_across);
      REG_CELLS_DOWN:   prdata = APB_DW'(cells_down);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    cfg.cell_w = (cell_width == '0) ? CFG_W'(1) : cell_width;
    cfg.cell_h = (cell_height == '0) ? CFG_W'(1) : cell_height;
    cfg.map_w  = map_width;
    cfg.map_h  = map_height;
    cfg.cols   = (32'(cells_across) > GRID_COLUMNS) ? CNT_W'(GRID_COLUMNS)
                                                    : CNT_W'(cells_across);
    cfg.rows   = (32'(cells_down) > GRID_ROWS) ? CNT_W'(GRID_ROWS)
                                               : CNT_W'(cells_down);
  end

endmodule

// ----- rtl/occupancy_grid_polygon_raster_unit.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_polygon_raster_unit
// Occupancy grid with polygon scanline fill, segment checks and point queries.
// ----------------------------------------------------------------------------
// After reset the unit clears its 4096-cell grid, one cell a cycle, and takes
// no item while it clears. A vertex that is not the last one is stored at
// once and the unit stays ready. Everything else runs on one shared divider
// under a sequencer: a point query divides by the cell width and height and
// reads the cell; a segment check or each polygon edge divides to find its
// start cell and then, for every grid column it crosses, does one multiply and
// two divisions and visits each covered row. The fill then reads each row span
// and visits each cell of the span. The unit works on one item at a time; a
// result waiting in the output register does not block the next item.
module occupancy_grid_polygon_raster_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  operation,
  input  logic [ogpr_pkg::PIX_W-1:0]  x_a,
  input  logic [ogpr_pkg::PIX_W-1:0]  y_a,
  input  logic [ogpr_pkg::PIX_W-1:0]  x_b,
  input  logic [ogpr_pkg::PIX_W-1:0]  y_b,
  input  logic [ogpr_pkg::TYPE_W-1:0] object_type,
  input  logic                        last_vertex,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic [ogpr_pkg::TYPE_W-1:0] cell_type,
  output logic [ogpr_pkg::STAT_W-1:0] status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ogpr_pkg::APB_AW-1:0] paddr,
  input  logic [ogpr_pkg::APB_DW-1:0] pwdata,
  output logic [ogpr_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import ogpr_pkg::*;

  typedef enum logic [24:0] {
    ST_CLEAR   = 25'd1 << 0,
    ST_IDLE    = 25'd1 << 1,
    ST_F_A     = 25'd1 << 2,
    ST_F_B     = 25'd1 << 3,
    ST_W_INIT  = 25'd1 << 4,
    ST_W_DIVJ  = 25'd1 << 5,
    ST_W_DIVI  = 25'd1 << 6,
    ST_W_COL   = 25'd1 << 7,
    ST_W_STEP  = 25'd1 << 8,
    ST_W_MUL   = 25'd1 << 9,
    ST_W_DIVQ  = 25'd1 << 10,
    ST_W_DIVN  = 25'd1 << 11,
    ST_V_RD    = 25'd1 << 12,
    ST_V_DATA  = 25'd1 << 13,
    ST_W_ADV   = 25'd1 << 14,
    ST_W_END   = 25'd1 << 15,
    ST_F_ROW   = 25'd1 << 16,
    ST_F_RDATA = 25'd1 << 17,
    ST_F_CRD   = 25'd1 << 18,
    ST_F_CWR   = 25'd1 << 19,
    ST_Q_DIVX  = 25'd1 << 20,
    ST_Q_DIVY  = 25'd1 << 21,
    ST_Q_RD    = 25'd1 << 22,
    ST_Q_DATA  = 25'd1 << 23,
    ST_RESULT  = 25'd1 << 24
  } state_t;

  state_t state;
  cfg_t   cfg;

  logic [GRID_AW-1:0]  clr;
  logic [VC_W-1:0]     vcount, nverts, vc_new;
  logic [VI_W-1:0]     s;
  logic [PIX_W-1:0]    vx [MAX_VERTICES];
  logic [PIX_W-1:0]    vy [MAX_VERTICES];
  logic [TYPE_W-1:0]   ftype, want, res_cell;
  logic [STAT_W-1:0]   res_status;
  logic                record, hit_acc;
  logic [PIX_W-1:0]    ax, ay, bx, by, xs, ys, xe, ye, cx, cy;
  logic [PIX_W-1:0]    i, j, k, ni, hi, nx, ny, dy_abs;
  logic                dy_neg;
  logic [BND_W-1:0]    bound;
  logic [DIV_NW-1:0]   prod;
  logic [COL_W-1:0]    cend;
  logic [GRID_ROWS-1:0] row_valid;

  logic                div_go, div_done, div_start;
  logic [DIV_NW-1:0]   div_num, div_q;
  logic [DIV_DW-1:0]   div_den, div_r;

  logic                grid_we;
  logic [GRID_AW-1:0]  grid_waddr, cell_addr;
  logic [TYPE_W-1:0]   grid_wdata, grid_rdata;
  logic                row_we;
  logic [2*COL_W-1:0]  row_wdata, row_rdata;
  logic [ROW_W-1:0]    kr;

  logic [VC_W-1:0]     s_inc;
  logic [VI_W-1:0]     t_idx, vidx;
  logic [PIX_W-1:0]    vrd_x, vrd_y;
  logic [PIX_W-1:0]    q_pix, lo, hi_c, rows_p, cols_p, hi_eff, dx_col;
  logic [PIX_W-1:0]    ny_calc;
  logic                skip, a_first, row_ok;
  logic [COL_W-1:0]    old_l, old_r, jc, new_l, new_r, span_r, cend_calc;
  logic [CNT_W-1:0]    span_l, cols_m1;
  logic                span_ok;
  logic [CFG_W-1:0]    xa_w, ya_w, xb_w, yb_w;
  logic                a_in_map, b_in_map;

  ogpr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ogpr_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_q),
    .rem  (div_r),
    .done (div_done)
  );

  ogpr_ram #(.WIDTH(TYPE_W), .DEPTH(GRID_DEPTH)) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .raddr (cell_addr),
    .rdata (grid_rdata)
  );

  ogpr_ram #(.WIDTH(2 * COL_W), .DEPTH(2 ** ROW_W)) u_span (
    .clk   (clk),
    .we    (row_we),
    .waddr (kr),
    .wdata (row_wdata),
    .raddr (kr),
    .rdata (row_rdata)
  );

  assign in_ready = (state == ST_IDLE);

  assign xa_w     = CFG_W'(x_a);
  assign ya_w     = CFG_W'(y_a);
  assign xb_w     = CFG_W'(x_b);
  assign yb_w     = CFG_W'(y_b);
  assign a_in_map = (xa_w < cfg.map_w) && (ya_w < cfg.map_h);
  assign b_in_map = (xb_w < cfg.map_w) && (yb_w < cfg.map_h);

  assign vc_new = (vcount < VC_W'(MAX_VERTICES)) ? vcount + 1'b1 : VC_W'(MAX_VERTICES + 1);

  assign s_inc = VC_W'(s) + 1'b1;
  assign t_idx = (s_inc == nverts) ? '0 : s_inc[VI_W-1:0];
  assign vidx  = (state == ST_F_A) ? s : t_idx;
  assign vrd_x = vx[vidx];
  assign vrd_y = vy[vidx];

  assign kr        = k[ROW_W-1:0];
  assign jc        = j[COL_W-1:0];
  assign cell_addr = {kr, jc};

  assign rows_p  = PIX_W'(cfg.rows);
  assign cols_p  = PIX_W'(cfg.cols);
  assign q_pix   = div_q[PIX_W-1:0];
  assign lo      = (i < q_pix) ? i : q_pix;
  assign hi_c    = (i < q_pix) ? q_pix : i;
  assign skip    = (j >= cols_p) || (lo >= rows_p);
  assign hi_eff  = (hi_c >= rows_p) ? rows_p - 1'b1 : hi_c;
  assign dx_col  = nx - xs;
  assign ny_calc = dy_neg ? ys - q_pix - PIX_W'(div_r != '0) : ys + q_pix;
  assign a_first = ax < bx;

  assign div_start = ((state == ST_IDLE) && in_valid && (operation == OP_QUERY) &&
                      a_in_map) ||
                     (state == ST_W_INIT) ||
                     ((state == ST_W_STEP) && (nx == cx)) ||
                     (state == ST_W_MUL) ||
                     (div_done && ((state == ST_W_DIVJ) || (state == ST_W_DIVQ) ||
                                   (state == ST_Q_DIVX)));

  assign row_ok    = row_valid[kr];
  assign old_l     = row_rdata[2*COL_W-1:COL_W];
  assign old_r     = row_rdata[COL_W-1:0];
  assign new_l     = (row_ok && old_l < jc) ? old_l : jc;
  assign new_r     = (row_ok && old_r > jc) ? old_r : jc;
  assign row_we    = (state == ST_V_DATA) && record;
  assign row_wdata = {new_l, new_r};

  assign span_l    = row_ok ? CNT_W'(old_l) : cfg.cols;
  assign span_r    = row_ok ? old_r : '0;
  assign cols_m1   = cfg.cols - 1'b1;
  assign cend_calc = (CNT_W'(span_r) > cols_m1) ? cols_m1[COL_W-1:0] : span_r;
  assign span_ok   = (cfg.cols != '0) && (span_l <= CNT_W'(cend_calc));

  assign grid_we    = (state == ST_CLEAR) ||
                      ((state == ST_F_CWR) && (grid_rdata != TYPE_OBSTACLE));
  assign grid_waddr = (state == ST_CLEAR) ? clr : cell_addr;
  assign grid_wdata = (state == ST_CLEAR) ? '0 : ftype;

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid && operation == OP_VERTEX &&
        vcount < VC_W'(MAX_VERTICES)) begin
      vx[vcount[VI_W-1:0]] <= x_a;
      vy[vcount[VI_W-1:0]] <= y_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      vcount    <= '0;
      ftype     <= '0;
      out_valid <= 1'b0;
      div_go    <= 1'b0;
      row_valid <= '0;
    end else begin
      div_go <= div_start;
      if (out_valid && out_ready && state != ST_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == GRID_AW'(GRID_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            hit_acc    <= 1'b0;
            res_cell   <= (operation == OP_QUERY && !a_in_map) ? TYPE_OUT_OF_MAP : '0;
            res_status <= (operation != OP_VERTEX || !last_vertex) ? STATUS_OK :
                          (vc_new > VC_W'(MAX_VERTICES)) ? STATUS_MANY :
                          (vc_new < VC_W'(MIN_VERTICES)) ? STATUS_FEW : STATUS_OK;
            want       <= object_type;
            case (operation)
              OP_VERTEX: begin
                ftype <= object_type;
                if (!last_vertex) begin
                  vcount <= vc_new;
                end else begin
                  vcount <= '0;
                  nverts <= vc_new;
                  if (vc_new > VC_W'(MAX_VERTICES)) begin
                    state <= ST_RESULT;
                  end else if (vc_new < VC_W'(MIN_VERTICES)) begin
                    state <= ST_RESULT;
                  end else if (object_type > TYPE_HIGHEST) begin
                    state <= ST_RESULT;
                  end else begin
                    s         <= '0;
                    record    <= 1'b1;
                    row_valid <= '0;
                    state     <= ST_F_A;
                  end
                end
              end
              OP_CHECK: begin
                ax     <= x_a;
                ay     <= y_a;
                bx     <= x_b;
                by     <= y_b;
                record <= 1'b0;
                state  <= (a_in_map && b_in_map) ? ST_W_INIT : ST_RESULT;
              end
              OP_QUERY: begin
                if (a_in_map) begin
                  k       <= y_a;
                  div_num <= DIV_NW'(x_a);
                  div_den <= cfg.cell_w;
                  state   <= ST_Q_DIVX;
                end else begin
                  state <= ST_RESULT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_F_A: begin
          ax    <= vrd_x;
          ay    <= vrd_y;
          state <= ST_F_B;
        end
        ST_F_B: begin
          bx    <= vrd_x;
          by    <= vrd_y;
          state <= ST_W_INIT;
        end
        ST_W_INIT: begin
          xs      <= a_first ? ax : bx;
          ys      <= a_first ? ay : by;
          xe      <= a_first ? bx : ax;
          ye      <= a_first ? by : ay;
          cx      <= a_first ? ax : bx;
          cy      <= a_first ? ay : by;
          div_num <= DIV_NW'(a_first ? ax : bx);
          div_den <= cfg.cell_w;
          state   <= ST_W_DIVJ;
        end
        ST_W_DIVJ: begin
          if (div_done) begin
            j       <= q_pix;
            bound   <= BND_W'(xs) - BND_W'(div_r) + BND_W'(cfg.cell_w);
            div_num <= DIV_NW'(ys);
            div_den <= cfg.cell_h;
            state   <= ST_W_DIVI;
          end
        end
        ST_W_DIVI: begin
          if (div_done) begin
            i      <= q_pix;
            dy_neg <= ye < ys;
            dy_abs <= (ye < ys) ? ys - ye : ye - ys;
            state  <= (cx == xe && cy == ye) ? ST_W_END : ST_W_COL;
          end
        end
        ST_W_COL: begin
          nx    <= (bound < BND_W'(xe)) ? bound[PIX_W-1:0] : xe;
          state <= ST_W_STEP;
        end
        ST_W_STEP: begin
          if (nx == cx) begin
            ny      <= ye;
            div_num <= DIV_NW'(ye);
            div_den <= cfg.cell_h;
            state   <= ST_W_DIVN;
          end else begin
            prod  <= {{PIX_W{1'b0}}, dx_col} * {{PIX_W{1'b0}}, dy_abs};
            state <= ST_W_MUL;
          end
        end
        ST_W_MUL: begin
          div_num <= prod;
          div_den <= DIV_DW'(xe - xs);
          state   <= ST_W_DIVQ;
        end
        ST_W_DIVQ: begin
          if (div_done) begin
            ny      <= ny_calc;
            div_num <= DIV_NW'(ny_calc);
            div_den <= cfg.cell_h;
            state   <= ST_W_DIVN;
          end
        end
        ST_W_DIVN: begin
          if (div_done) begin
            ni    <= q_pix;
            k     <= lo;
            hi    <= hi_eff;
            state <= skip ? ST_W_ADV : ST_V_RD;
          end
        end
        ST_V_RD: begin
          state <= ST_V_DATA;
        end
        ST_V_DATA: begin
          if (record) begin
            row_valid[kr] <= 1'b1;
          end else if (grid_rdata == want) begin
            hit_acc <= 1'b1;
          end
          if (k == hi) begin
            state <= ST_W_ADV;
          end else begin
            k     <= k + 1'b1;
            state <= ST_V_RD;
          end
        end
        ST_W_ADV: begin
          cx    <= nx;
          cy    <= ny;
          j     <= j + 1'b1;
          i     <= ni;
          bound <= bound + BND_W'(cfg.cell_w);
          state <= (nx == xe && ny == ye) ? ST_W_END : ST_W_COL;
        end
        ST_W_END: begin
          if (!record) begin
            state <= ST_RESULT;
          end else if (s_inc == nverts) begin
            k     <= '0;
            state <= (cfg.rows == '0) ? ST_RESULT : ST_F_ROW;
          end else begin
            s     <= s_inc[VI_W-1:0];
            state <= ST_F_A;
          end
        end
        ST_F_ROW: begin
          state <= ST_F_RDATA;
        end
        ST_F_RDATA: begin
          cend <= cend_calc;
          j    <= PIX_W'(span_l);
          if (span_ok) begin
            state <= ST_F_CRD;
          end else if (k == rows_p - 1'b1) begin
            state <= ST_RESULT;
          end else begin
            k     <= k + 1'b1;
            state <= ST_F_ROW;
          end
        end
        ST_F_CRD: begin
          state <= ST_F_CWR;
        end
        ST_F_CWR: begin
          if (jc != cend) begin
            j     <= j + 1'b1;
            state <= ST_F_CRD;
          end else if (k == rows_p - 1'b1) begin
            state <= ST_RESULT;
          end else begin
            k     <= k + 1'b1;
            state <= ST_F_ROW;
          end
        end
        ST_Q_DIVX: begin
          if (div_done) begin
            j       <= q_pix;
            div_num <= DIV_NW'(k);
            div_den <= cfg.cell_h;
            state   <= ST_Q_DIVY;
          end
        end
        ST_Q_DIVY: begin
          if (div_done) begin
            k <= q_pix;
            if (q_pix < rows_p && j < cols_p) begin
              state <= ST_Q_RD;
            end else begin
              res_cell <= TYPE_OUT_OF_MAP;
              state    <= ST_RESULT;
            end
          end
        end
        ST_Q_RD: begin
          state <= ST_Q_DATA;
        end
        ST_Q_DATA: begin
          res_cell <= grid_rdata;
          state    <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            hit       <= hit_acc;
            cell_type <= res_cell;
            status    <= res_status;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_div_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_W_DIVJ || state == ST_W_DIVI || state == ST_W_DIVQ ||
                  state == ST_W_DIVN || state == ST_Q_DIVX || state == ST_Q_DIVY))
    else $error("divider result arrived outside a wait state");

  a_vcount_sat: assert property (@(posedge clk) disable iff (rst)
    vcount <= VC_W'(MAX_VERTICES + 1))
    else $error("vertex count beyond saturation");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |-> (!hit && cell_type == '0))
    else $error("polygon error result carries hit or cell type");

endmodule
